[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of the buffer cache block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define BBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buffer cache check failed");

// Next-cycle implication, disabled while reset is held
`define BBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buffer cache check failed");

`endif

[hw/rtl/bbc_pkg.sv]
// Shared types and constants of the buffer cache tag table block.
// No dependencies; used by bbc_table, block_buffer_cache_lru and bbc_checker.
`default_nettype none

package bbc_pkg;

  // Table geometry
  localparam int NUM_SLOTS   = 32;
  localparam int BLOCK_WIDTH = 32;
  localparam int TIME_WIDTH  = 32;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);

  // Fixed field widths
  localparam int DEV_W      = 8;
  localparam int REFS_W     = 8;
  localparam int SLOT_IN_W  = 5;
  localparam int SLOT_OUT_W = 5;
  localparam int BLK_IN_W   = 32;
  localparam int NOW_IN_W   = 32;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  // Stream widths
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_GET     = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_PIN     = 2'd2,
    MODE_UNPIN   = 2'd3
  } bbc_mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_UNDER  = 2'd2,
    ST_OVER   = 2'd3
  } bbc_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } bbc_state_e;

  // One slot as read from the table
  typedef struct packed {
    logic [DEV_W-1:0]       device;
    logic [BLOCK_WIDTH-1:0] block;
    logic                   valid;
    logic [REFS_W-1:0]      refs;
    logic [TIME_WIDTH-1:0]  stamp;
  } bbc_entry_t;

  // Write request into the table
  typedef struct packed {
    logic                   en;
    logic [SLOT_W-1:0]      idx;
    logic                   tag_en;
    logic [DEV_W-1:0]       device;
    logic [BLOCK_WIDTH-1:0] block;
    logic                   valid_set;
    logic                   refs_en;
    logic [REFS_W-1:0]      refs;
    logic                   stamp_en;
    logic [TIME_WIDTH-1:0]  stamp;
  } bbc_wr_t;

endpackage

`default_nettype wire

[hw/rtl/block_buffer_cache_lru.sv]
// Buffer cache tag table with least-recently-released replacement.
// Depends on bbc_pkg and bbc_table.
//
// A get request walks the slot table one slot per cycle through a single
// tag and release-time comparator: it stops at the first matching tag, and
// otherwise keeps the unreferenced slot with the oldest release time. A get
// goes through the accept, scan and finish steps, and its scan stops early
// when it hits. Release, pin and unpin touch one slot and go from accept
// straight to finish. The next request is taken once the result has been
// loaded into the output register; a result that waits there holds the finish step.
`default_nettype none

module block_buffer_cache_lru (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // in_tdata: device[7:0], block_number[39:8], slot_in[44:40], now[76:45]
  input  wire logic [bbc_pkg::IN_DATA_W-1:0] in_tdata,
  // in_tuser: mode[1:0]
  input  wire logic [bbc_pkg::IN_USER_W-1:0] in_tuser,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // out_tdata: slot_out[4:0], hit[5], needs_fill[6], status[8:7]
  output logic [bbc_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready
);
  import bbc_pkg::*;

  // Request fields
  logic [DEV_W-1:0]     in_device;
  logic [BLK_IN_W-1:0]  in_block;
  logic [SLOT_IN_W-1:0] in_slot;
  logic [NOW_IN_W-1:0]  in_now;

  assign in_device = in_tdata[7:0];
  assign in_block  = in_tdata[39:8];
  assign in_slot   = in_tdata[44:40];
  assign in_now    = in_tdata[76:45];

  bbc_state_e state_r, state_nxt;

  bbc_mode_e              mode_r, mode_nxt;
  logic [DEV_W-1:0]       dev_r, dev_nxt;
  logic [BLOCK_WIDTH-1:0] blk_r, blk_nxt;
  logic [SLOT_IN_W-1:0]   slot_r, slot_nxt;
  logic [TIME_WIDTH-1:0]  now_r, now_nxt;
  logic [SLOT_W-1:0]      idx_r, idx_nxt;
  logic [SLOT_W-1:0]      tgt_r, tgt_nxt;
  logic                   hit_r, hit_nxt;
  logic                   found_r, found_nxt;
  logic [TIME_WIDTH-1:0]  best_r, best_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [SLOT_OUT_W-1:0]  out_slot_r, out_slot_nxt;
  logic                   out_hit_r, out_hit_nxt;
  logic                   out_fill_r, out_fill_nxt;
  bbc_status_e            out_status_r, out_status_nxt;

  logic [SLOT_W-1:0] rd_idx;
  bbc_entry_t        rd;
  bbc_wr_t           wr;

  logic tag_eq;
  logic older;
  logic out_free;
  logic slot_oor;

  bbc_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (rd_idx),
    .rd     (rd),
    .wr     (wr)
  );

  // Shared comparator: tag match and older release time
  assign tag_eq   = (rd.device == dev_r) && (rd.block == blk_r);
  assign older    = !found_r || (rd.stamp < best_r);
  assign out_free = !out_valid_r || out_tready;
  assign slot_oor = 32'(slot_r) >= 32'(NUM_SLOTS);
  assign rd_idx   = (state_r == S_SCAN) ? idx_r : tgt_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_status_r, out_fill_r, out_hit_r, out_slot_r};

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    dev_r        <= dev_nxt;
    blk_r        <= blk_nxt;
    slot_r       <= slot_nxt;
    now_r        <= now_nxt;
    idx_r        <= idx_nxt;
    tgt_r        <= tgt_nxt;
    hit_r        <= hit_nxt;
    found_r      <= found_nxt;
    best_r       <= best_nxt;
    out_slot_r   <= out_slot_nxt;
    out_hit_r    <= out_hit_nxt;
    out_fill_r   <= out_fill_nxt;
    out_status_r <= out_status_nxt;
  end

  // Sequencer: accept, scan, finish
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    dev_nxt        = dev_r;
    blk_nxt        = blk_r;
    slot_nxt       = slot_r;
    now_nxt        = now_r;
    idx_nxt        = idx_r;
    tgt_nxt        = tgt_r;
    hit_nxt        = hit_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_slot_nxt   = out_slot_r;
    out_hit_nxt    = out_hit_r;
    out_fill_nxt   = out_fill_r;
    out_status_nxt = out_status_r;
    wr             = '0;
    wr.idx         = tgt_r;
    wr.device      = dev_r;
    wr.block       = blk_r;
    wr.stamp       = now_r;

    unique case (state_r)
      S_IDLE: begin
        // Latch the request; a get starts the walk, other modes go to finish
        if (in_tvalid) begin
          mode_nxt  = bbc_mode_e'(in_tuser);
          dev_nxt   = in_device;
          blk_nxt   = BLOCK_WIDTH'(in_block);
          slot_nxt  = in_slot;
          now_nxt   = TIME_WIDTH'(in_now);
          idx_nxt   = '0;
          tgt_nxt   = SLOT_W'(in_slot);
          hit_nxt   = 1'b0;
          found_nxt = 1'b0;
          best_nxt  = '0;
          state_nxt = (bbc_mode_e'(in_tuser) == MODE_GET) ? S_SCAN : S_FIN;
        end
      end

      S_SCAN: begin
        // Stop at the first matching tag, else track the oldest free slot
        if (tag_eq) begin
          hit_nxt   = 1'b1;
          tgt_nxt   = idx_r;
          state_nxt = S_FIN;
        end else begin
          if ((rd.refs == '0) && older) begin
            found_nxt = 1'b1;
            tgt_nxt   = idx_r;
            best_nxt  = rd.stamp;
          end
          if (idx_r == SLOT_W'(NUM_SLOTS - 1)) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      S_FIN: begin
        // Update the chosen slot and load the result
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
          out_slot_nxt   = SLOT_OUT_W'(slot_r);
          out_hit_nxt    = 1'b0;
          out_fill_nxt   = 1'b0;
          out_status_nxt = ST_OK;
          if (mode_r == MODE_GET) begin
            out_slot_nxt = SLOT_OUT_W'(tgt_r);
            if (hit_r) begin
              out_hit_nxt = 1'b1;
              if (rd.refs == REFS_MAX) begin
                out_status_nxt = ST_OVER;
              end else begin
                wr.en        = 1'b1;
                wr.refs_en   = 1'b1;
                wr.refs      = rd.refs + 1'b1;
                wr.valid_set = 1'b1;
                out_fill_nxt = !rd.valid;
              end
            end else if (!found_r) begin
              out_slot_nxt   = '0;
              out_status_nxt = ST_NOFREE;
            end else begin
              wr.en        = 1'b1;
              wr.tag_en    = 1'b1;
              wr.refs_en   = 1'b1;
              wr.refs      = REFS_W'(1);
              wr.valid_set = 1'b1;
              out_fill_nxt = 1'b1;
            end
          end else if (!slot_oor) begin
            case (mode_r) inside
              MODE_PIN: begin
                if (rd.refs == REFS_MAX) begin
                  out_status_nxt = ST_OVER;
                end else begin
                  wr.en      = 1'b1;
                  wr.refs_en = 1'b1;
                  wr.refs    = rd.refs + 1'b1;
                end
              end
              MODE_RELEASE, MODE_UNPIN: begin
                if (rd.refs == '0) begin
                  out_status_nxt = ST_UNDER;
                end else begin
                  wr.en       = 1'b1;
                  wr.refs_en  = 1'b1;
                  wr.refs     = rd.refs - 1'b1;
                  wr.stamp_en = (mode_r == MODE_RELEASE) && (rd.refs == REFS_W'(1));
                end
              end
              default: begin
                out_status_nxt = ST_OK;
              end
            endcase
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/bbc_table.sv]
// Slot tag table: device, block, valid, reference count and release time.
// Depends on bbc_pkg. One read index and one write request per cycle.
`default_nettype none

module bbc_table (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [bbc_pkg::SLOT_W-1:0] rd_idx,
  output bbc_pkg::bbc_entry_t            rd,
  input  wire bbc_pkg::bbc_wr_t          wr
);
  import bbc_pkg::*;

  logic [DEV_W-1:0]       device_r [NUM_SLOTS];
  logic [BLOCK_WIDTH-1:0] block_r  [NUM_SLOTS];
  logic                   valid_r  [NUM_SLOTS];
  logic [REFS_W-1:0]      refs_r   [NUM_SLOTS];
  logic [TIME_WIDTH-1:0]  stamp_r  [NUM_SLOTS];

  // Clear every slot on reset, then apply the write request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        device_r[i] <= '0;
        block_r[i]  <= '0;
        valid_r[i]  <= 1'b0;
        refs_r[i]   <= '0;
        stamp_r[i]  <= '0;
      end
    end else if (wr.en) begin
      if (wr.tag_en) begin
        device_r[wr.idx] <= wr.device;
        block_r[wr.idx]  <= wr.block;
      end
      if (wr.valid_set) begin
        valid_r[wr.idx] <= 1'b1;
      end
      if (wr.refs_en) begin
        refs_r[wr.idx] <= wr.refs;
      end
      if (wr.stamp_en) begin
        stamp_r[wr.idx] <= wr.stamp;
      end
    end
  end

  // Read the selected slot
  always_comb begin
    rd.device = device_r[rd_idx];
    rd.block  = block_r[rd_idx];
    rd.valid  = valid_r[rd_idx];
    rd.refs   = refs_r[rd_idx];
    rd.stamp  = stamp_r[rd_idx];
  end

endmodule

`default_nettype wire

[hw/rtl/bbc_checker.sv]
// Port-level checks of block_buffer_cache_lru, attached by bind below.
// Depends on bbc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bbc_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [bbc_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready
);
  import bbc_pkg::*;

  logic [SLOT_OUT_W-1:0] slot_out;
  logic                  hit;
  logic                  fill;
  logic [1:0]            status;

  assign slot_out = out_tdata[4:0];
  assign hit      = out_tdata[5];
  assign fill     = out_tdata[6];
  assign status   = out_tdata[8:7];

  // Busy after a request is taken
  `BBC_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  // Stalled result holds
  `BBC_ASSERT_NXT(a_result_holds, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // No free buffer answers slot zero and no flags
  `BBC_ASSERT_IMP(a_nofree_clean, out_tvalid && (status == ST_NOFREE), (slot_out == '0) && !hit && !fill)
  // A fill is only asked for on success
  `BBC_ASSERT_IMP(a_fill_ok, out_tvalid && fill, status == ST_OK)

endmodule

bind block_buffer_cache_lru bbc_checker u_bbc_checker (.*);

`default_nettype wire

[dv/tb_bbc_tag_check.sv]
`timescale 1ns / 1ps
// Scoreboard for the buffer cache tag table. It keeps a shadow copy of the slot
// table, works out the answer to each request and compares the result stream with it.
// Depends on bbc_pkg only.
module tb_bbc_tag_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bbc_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [bbc_pkg::IN_USER_W-1:0] in_tuser,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [bbc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  output int                            mismatches,
  output int                            outstanding
);
  import bbc_pkg::*;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    logic                  hit;
    logic                  fill;
    bbc_status_e           status;
  } answer_t;

  // Shadow slot table
  logic [DEV_W-1:0]       tag_dev       [NUM_SLOTS];
  logic [BLOCK_WIDTH-1:0] tag_blk       [NUM_SLOTS];
  logic                   line_valid    [NUM_SLOTS];
  logic [REFS_W-1:0]      ref_count     [NUM_SLOTS];
  logic [TIME_WIDTH-1:0]  release_stamp [NUM_SLOTS];

  // Answers owed by the block, oldest first
  answer_t answers_q[$];

  // Apply one request to the shadow table and return the answer it earns
  function automatic answer_t apply_request(input bbc_mode_e mode,
                                            input logic [DEV_W-1:0] dev,
                                            input logic [BLOCK_WIDTH-1:0] blk,
                                            input logic [SLOT_IN_W-1:0] idx,
                                            input logic [TIME_WIDTH-1:0] now);
    answer_t a;
    int      i;
    int      hit_at;
    int      victim;
    a.slot   = idx;
    a.hit    = 1'b0;
    a.fill   = 1'b0;
    a.status = ST_OK;
    if (mode == MODE_GET) begin
      // first matching tag wins, valid or not
      hit_at = -1;
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (hit_at < 0 && tag_dev[i] == dev && tag_blk[i] == blk) hit_at = i;
      end
      if (hit_at >= 0) begin
        a.slot = hit_at[SLOT_OUT_W-1:0];
        a.hit  = 1'b1;
        if (ref_count[hit_at] == REFS_MAX) begin
          a.status = ST_OVER;
        end else begin
          ref_count[hit_at]  = ref_count[hit_at] + 1'b1;
          a.fill             = !line_valid[hit_at];
          line_valid[hit_at] = 1'b1;
        end
      end else begin
        // oldest release time among idle slots, lowest index on ties
        victim = -1;
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (ref_count[i] == '0 &&
              (victim < 0 || release_stamp[i] < release_stamp[victim])) victim = i;
        end
        if (victim < 0) begin
          a.slot   = '0;
          a.status = ST_NOFREE;
        end else begin
          tag_dev[victim]    = dev;
          tag_blk[victim]    = blk;
          ref_count[victim]  = REFS_W'(1);
          line_valid[victim] = 1'b1;
          a.slot             = victim[SLOT_OUT_W-1:0];
          a.fill             = 1'b1;
        end
      end
    end else if (mode == MODE_PIN) begin
      if (ref_count[idx] == REFS_MAX) a.status = ST_OVER;
      else ref_count[idx] = ref_count[idx] + 1'b1;
    end else begin
      // release and unpin both drop a reference; only release stamps the time
      if (ref_count[idx] == '0) begin
        a.status = ST_UNDER;
      end else begin
        ref_count[idx] = ref_count[idx] - 1'b1;
        if (mode == MODE_RELEASE && ref_count[idx] == '0) release_stamp[idx] = now;
      end
    end
    return a;
  endfunction

  task automatic flag_mismatch(input string what, input int got_v, input int want_v);
    $display("%0t: tag check: %s got %0d, expected %0d", $time, what, got_v, want_v);
    mismatches++;
  endtask

  // Pop an answer for each result taken, then queue one for each request taken
  always @(posedge clk) begin : watch
    answer_t got;
    answer_t want;
    int      i;
    if (!rst_n) begin
      for (i = 0; i < NUM_SLOTS; i++) begin
        tag_dev[i]       = '0;
        tag_blk[i]       = '0;
        line_valid[i]    = 1'b0;
        ref_count[i]     = '0;
        release_stamp[i] = '0;
      end
      answers_q.delete();
      mismatches = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.slot   = out_tdata[4:0];
        got.hit    = out_tdata[5];
        got.fill   = out_tdata[6];
        got.status = bbc_status_e'(out_tdata[8:7]);
        if (answers_q.size() == 0) begin
          flag_mismatch("result with no request outstanding, slot_out", int'(got.slot), -1);
        end else begin
          want = answers_q.pop_front();
          if (got.slot != want.slot)
            flag_mismatch("slot_out", int'(got.slot), int'(want.slot));
          if (got.hit != want.hit)
            flag_mismatch("hit", int'(got.hit), int'(want.hit));
          if (got.fill != want.fill)
            flag_mismatch("needs_fill", int'(got.fill), int'(want.fill));
          if (got.status != want.status)
            flag_mismatch("status", int'(got.status), int'(want.status));
        end
      end
      if (in_tvalid && in_tready) begin
        answers_q.push_back(apply_request(bbc_mode_e'(in_tuser), in_tdata[7:0],
                                          in_tdata[39:8], in_tdata[44:40],
                                          in_tdata[76:45]));
      end
    end
    outstanding <= answers_q.size();
  end

endmodule

[dv/tb_block_buffer_cache_lru.sv]
`timescale 1ns / 1ps
// Top of the buffer cache tag table testbench: clock, reset, request stimulus
// and the verdict. Depends on bbc_pkg, block_buffer_cache_lru and tb_bbc_tag_check.
module tb_block_buffer_cache_lru;
  import bbc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 100;
  localparam int CALM_TAIL    = 30;
  localparam int TAIL_WAIT    = 60;
  localparam int POOL_SIZE    = 16;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  out_tready = 1'b0;
  wire                   in_tready;
  wire [OUT_DATA_W-1:0]  out_tdata;
  wire                   out_tvalid;

  int                    bad_results;
  int                    in_flight;
  int                    cycles    = 0;
  int                    hold_left = 0;
  bit                    calm      = 1'b0;
  logic [SLOT_OUT_W-1:0] last_slot = '0;

  // Tags that requests keep coming back to, so that gets hit
  logic [DEV_W-1:0]       dev_pool [POOL_SIZE];
  logic [BLOCK_WIDTH-1:0] blk_pool [POOL_SIZE];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  block_buffer_cache_lru dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  tb_bbc_tag_check tag_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .mismatches  (bad_results),
    .outstanding (in_flight)
  );

  // Watchdog; also note the slot of the latest result
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (out_tvalid && out_tready) last_slot <= out_tdata[4:0];
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb_block_buffer_cache_lru: errors");
      $finish;
    end
  end

  // Stall the result side in random bursts, except in the calm tail
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      hold_left  <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Present one request, with an occasional gap first, and hold it until taken
  task automatic push_request(input bbc_mode_e mode, input logic [31:0] dev,
                              input logic [31:0] blk,
                              input logic [31:0] idx,
                              input logic [31:0] now);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tdata  <= {3'b000, now[NOW_IN_W-1:0], idx[SLOT_IN_W-1:0], blk[BLK_IN_W-1:0],
                  dev[DEV_W-1:0]};
    in_tuser  <= mode;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold off until every outstanding request has been answered
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  // Release times: mostly spread, often equal or at the extremes
  function automatic logic [NOW_IN_W-1:0] pick_now();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int                    k;
    int                    j;
    int                    s;
    logic [DEV_W-1:0]      d;
    logic [BLK_IN_W-1:0]   b;
    logic [SLOT_OUT_W-1:0] hot;
    dev_pool[0] = '0;
    blk_pool[0] = '0;
    dev_pool[1] = '1;
    blk_pool[1] = '1;
    for (k = 2; k < POOL_SIZE; k++) begin
      dev_pool[k] = DEV_W'($urandom);
      blk_pool[k] = $urandom;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset tags all read (0, 0): first get hits slot 0 with a fill, second without
    push_request(MODE_GET, 32'h00, 32'h0000_0000, $urandom, $urandom);
    push_request(MODE_GET, 32'h00, 32'h0000_0000, $urandom, $urandom);
    // Miss at the field extremes takes slot 1, then stamp it with the top time
    push_request(MODE_GET, 32'hff, 32'hffff_ffff, $urandom, $urandom);
    push_request(MODE_RELEASE, $urandom, $urandom, 32'd1, 32'hffff_ffff);
    push_request(MODE_RELEASE, $urandom, $urandom, 32'd1, $urandom);
    push_request(MODE_UNPIN, $urandom, $urandom, 32'd5, $urandom);
    // Pin and unpin only count; no stamp
    push_request(MODE_PIN, $urandom, $urandom, 32'd31, $urandom);
    push_request(MODE_UNPIN, $urandom, $urandom, 32'd31, 32'h7fff_ffff);
    push_request(MODE_RELEASE, $urandom, $urandom, 32'd0, 32'h1234_5678);
    push_request(MODE_RELEASE, $urandom, $urandom, 32'd0, 32'h0000_0000);
    // Ties on time zero go to the lowest index
    push_request(MODE_GET, 32'h5a, 32'h8000_0000, $urandom, $urandom);
    push_request(MODE_GET, 32'h00, 32'h0000_0000, $urandom, $urandom);
    push_request(MODE_GET, 32'h01, 32'h0000_0001, $urandom, $urandom);
    push_request(MODE_PIN, 32'hff, 32'hffff_ffff, 32'd16, 32'hffff_ffff);
    push_request(MODE_RELEASE, 32'h00, 32'h0000_0000, 32'd16, 32'h8000_0001);

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS - CALM_TAIL) calm = 1'b1;

      // Run out of idle slots, then drain references again
      if (k == 30) begin
        repeat (34) push_request(MODE_GET, $urandom, $urandom, $urandom, pick_now());
        for (s = 0; s < NUM_SLOTS; s++) begin
          repeat (4) push_request(MODE_RELEASE, $urandom, $urandom, s, pick_now());
        end
      end

      // Drive one slot's count to the ceiling through gets and a pin, then back to zero
      if (k == 60) begin
        d = DEV_W'($urandom);
        b = $urandom;
        push_request(MODE_GET, 32'(d), b, $urandom, pick_now());
        wait_drained();
        hot = last_slot;
        repeat (255) push_request(MODE_GET, 32'(d), b, $urandom, pick_now());
        push_request(MODE_PIN, $urandom, $urandom, 32'(hot), pick_now());
        repeat (256) push_request(MODE_RELEASE, $urandom, $urandom, 32'(hot), pick_now());
      end

      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          j = $urandom_range(0, POOL_SIZE - 1);
          d = dev_pool[j];
          b = blk_pool[j];
          if ($urandom_range(0, 4) == 0) begin
            d = DEV_W'($urandom);
            b = $urandom;
          end
          push_request(MODE_GET, 32'(d), b, $urandom, pick_now());
        end
        4, 5, 6, 7: push_request(MODE_RELEASE, $urandom, $urandom, $urandom, pick_now());
        8:          push_request(MODE_PIN, $urandom, $urandom, $urandom, pick_now());
        default:    push_request(MODE_UNPIN, $urandom, $urandom, $urandom, pick_now());
      endcase
    end

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (bad_results == 0) begin
      $display("tb_block_buffer_cache_lru: clean");
    end else begin
      $display("tb_block_buffer_cache_lru: errors");
    end
    $finish;
  end

endmodule
